[rtl/fbde_pkg.sv]
// ----------------------------------------------------------------------------
// fbde_pkg
// Shared types, codes and pixel arithmetic for the blend/draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fbde_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 9;
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 9'd256;
	localparam logic [31:0] OPAQUE = 32'hFF000000;
	localparam logic [7:0]  ALPHA_FULL = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLEND  = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_CLEAR     = 3'd0,
		OP_PLOT      = 3'd1,
		OP_FILL      = 3'd2,
		OP_BORDER    = 3'd3,
		OP_SPR_START = 3'd4,
		OP_SPR_ARGB  = 3'd5,
		OP_SPR_GREY  = 3'd6,
		OP_READ      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		PM_WRITE,
		PM_BLEND,
		PM_READ,
		PM_SKIP
	} pix_mode_t;

	typedef struct packed {
		logic      valid;
		pix_mode_t mode;
	} pix_ctl_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_SETUP,
		ST_RECT,
		ST_READ,
		ST_READ_WAIT,
		ST_DONE
	} eng_state_t;

	function automatic logic [7:0] mix_chan(input logic [7:0] s, input logic [7:0] d,
			input logic [7:0] a);
		logic [16:0] sum;
		sum = 17'({8'd0, s} * {8'd0, a}) + 17'({8'd0, d} * {8'd0, ~a});
		return sum[15:8];
	endfunction

	function automatic logic [31:0] mix(input logic [31:0] src, input logic [31:0] dst);
		logic [7:0] a;
		a = src[31:24];
		return OPAQUE | {8'd0, mix_chan(src[23:16], dst[23:16], a),
			mix_chan(src[15:8], dst[15:8], a), mix_chan(src[7:0], dst[7:0], a)};
	endfunction

endpackage

`default_nettype wire

[rtl/fbde_cmd_if.sv]
// ----------------------------------------------------------------------------
// fbde_cmd_if
// Command channel: opcode, position, size and color with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbde_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] size_w;
	logic signed [15:0] size_h;
	logic [31:0]        color;

	modport source(output valid, opcode, pos_x, pos_y, size_w, size_h, color, input ready);
	modport sink(input valid, opcode, pos_x, pos_y, size_w, size_h, color, output ready);
endinterface

`default_nettype wire

[rtl/fbde_res_if.sv]
// ----------------------------------------------------------------------------
// fbde_res_if
// Result channel: one read color per command with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbde_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_color;

	modport source(output valid, read_color, input ready);
	modport sink(input valid, read_color, output ready);
endinterface

`default_nettype wire

[rtl/fbde_store.sv]
// ----------------------------------------------------------------------------
// fbde_store
// Frame store with a two-stage read-modify-write pipe and write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module fbde_store
	import fbde_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pix_ctl_t      req,
	input  wire logic [AW-1:0] addr,
	input  wire logic [31:0]   wcolor,
	output      logic [31:0]   rdata
);

	logic [31:0]   mem_q [DEPTH];
	logic [31:0]   rd_s1;
	logic          v_s1;
	pix_mode_t     mode_s1;
	logic [AW-1:0] addr_s1;
	logic [31:0]   color_s1;
	logic          fwd_s1;
	logic [31:0]   fwd_data_s1;
	logic [31:0]   wdata;
	logic          we;

	always_comb begin
		rdata = fwd_s1 ? fwd_data_s1 : rd_s1;
		wdata = (mode_s1 == PM_BLEND) ? mix(color_s1, rdata) : color_s1;
		we    = v_s1 && (mode_s1 == PM_WRITE || mode_s1 == PM_BLEND);
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem_q[addr];
		if (we) begin
			mem_q[addr_s1] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= req.valid;
			fwd_s1 <= req.valid && we && (addr_s1 == addr);
		end
	end

	always_ff @(posedge clk) begin
		mode_s1     <= req.mode;
		addr_s1     <= addr;
		color_s1    <= wcolor;
		fwd_data_s1 <= wdata;
	end

endmodule

`default_nettype wire

[rtl/framebuffer_blend_draw_engine.sv]
// ----------------------------------------------------------------------------
// framebuffer_blend_draw_engine
// Command-driven ARGB8888 drawing engine with alpha blending.
//
// Commands arrive on cmd, one transaction each; every command returns exactly
// one transaction on res (read_color is the pixel for a read, else zero).
// Configuration (blend enable, active width, active height) is written over
// cfg_we / cfg_index / cfg_data only while the engine is idle: the user must
// keep to this, the block itself does not enforce it. Plot, fill and drawn
// sprite pixels go through ST_SETUP and then ST_RECT, which walks the covered
// pixels; border repeats ST_SETUP and ST_RECT for each side; clear sweeps
// width*height pixels in ST_CLEAR; read goes through ST_READ and ST_READ_WAIT;
// a command that draws nothing before setup goes straight to ST_DONE. Pixel
// throughput is set by the frame store: one read-modify-write per cycle, with
// the pending write or blend result forwarded to an immediately following access of the same pixel.
// A command is taken only while no command is in progress.
// After reset the whole frame store is swept to zero, during which cmd.ready
// stays low. A finished result sits in an output register; the next command
// is taken while it waits, and the engine holds that command's result until
// res drains.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_blend_draw_engine
	import fbde_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	fbde_cmd_if.sink                   cmd,
	fbde_res_if.source                 res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int PW    = WW + HW;

	typedef logic signed [19:0] coord_t;

	eng_state_t          state_q, state_d;
	logic                blend_q;
	logic [CFG_DATA_W-1:0] act_w_q, act_h_q;
	logic [WW-1:0]       w_eff;
	logic [HW-1:0]       h_eff;
	coord_t              w_ext, h_ext;

	op_t                 op_q;
	coord_t              x_q, y_q, w_q, h_q;
	logic [31:0]         color_q;
	pix_mode_t           mode_q;
	logic [1:0]          seg_q;
	coord_t              rx_q, ry_q, rw_q, rh_q;
	logic [WW-1:0]       x1_q, x2_q, cx_q;
	logic [HW-1:0]       y2_q, cy_q;
	logic [AW:0]         clr_q, clr_n_q;
	logic [31:0]         res_data_q;
	logic                out_valid_q;
	logic [31:0]         out_data_q;

	logic signed [15:0]  spr_ox_q, spr_oy_q, spr_w_q, spr_h_q, spr_col_q, spr_row_q;

	coord_t              in_x, in_y, in_w, in_h, spr_px, spr_py;
	logic                accept, in_inb, spr_ok, spr_inb, col_wrap;
	pix_mode_t           put_mode, spr_mode;
	logic [31:0]         spr_color;
	logic [PW-1:0]       area;

	coord_t              x1s, x2s, y1s, y2s, xe, ye;
	logic                rect_empty, rect_last, more_seg;
	logic [1:0]          seg_nx;
	coord_t              sg_x, sg_y, sg_w, sg_h;

	pix_ctl_t            st_req;
	logic [AW-1:0]       st_addr;
	logic [31:0]         st_color, st_rdata;
	logic [PW-1:0]       pix_prod;
	logic                out_load;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q <= 1'b0;
			act_w_q <= SIZE_RESET;
			act_h_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BLEND:  blend_q <= cfg_data[0];
				CFG_WIDTH:  act_w_q <= cfg_data;
				CFG_HEIGHT: act_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_eff = (32'(act_w_q) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(act_w_q);
		h_eff = (32'(act_h_q) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(act_h_q);
		w_ext = coord_t'(w_eff);
		h_ext = coord_t'(h_eff);
		area  = PW'(w_eff) * PW'(h_eff);
	end

	// command decode
	always_comb begin
		accept   = cmd.valid && cmd.ready;
		in_x     = coord_t'(cmd.pos_x);
		in_y     = coord_t'(cmd.pos_y);
		in_w     = coord_t'(cmd.size_w);
		in_h     = coord_t'(cmd.size_h);
		in_inb   = in_x >= 0 && in_y >= 0 && in_x < w_ext && in_y < h_ext;
		put_mode = PM_WRITE;
		if (blend_q && cmd.color[31:24] != ALPHA_FULL) begin
			put_mode = (cmd.color[31:24] == 8'd0) ? PM_SKIP : PM_BLEND;
		end
		spr_ok   = spr_w_q > 0 && spr_h_q > 0 && spr_row_q < spr_h_q;
		spr_px   = coord_t'(spr_ox_q) + coord_t'(spr_col_q);
		spr_py   = coord_t'(spr_oy_q) + coord_t'(spr_row_q);
		spr_inb  = spr_px >= 0 && spr_py >= 0 && spr_px < w_ext && spr_py < h_ext;
		col_wrap = (spr_col_q + 16'sd1) >= spr_w_q;
		if (op_t'(cmd.opcode) == OP_SPR_GREY) begin
			spr_color = OPAQUE | {8'd0, cmd.color[7:0], cmd.color[7:0], cmd.color[7:0]};
			spr_mode  = (cmd.color[7:0] == 8'd0) ? PM_SKIP : PM_WRITE;
		end else begin
			spr_color = cmd.color;
			if (cmd.color[31:24] == 8'd0) begin
				spr_mode = PM_SKIP;
			end else if (blend_q && cmd.color[31:24] != ALPHA_FULL) begin
				spr_mode = PM_BLEND;
			end else begin
				spr_mode = PM_WRITE;
			end
		end
	end

	// rectangle clipping and border sides
	always_comb begin
		xe = rx_q + rw_q;
		ye = ry_q + rh_q;
		x1s = (rx_q < 0) ? '0 : rx_q;
		y1s = (ry_q < 0) ? '0 : ry_q;
		x2s = (xe > w_ext) ? w_ext : xe;
		y2s = (ye > h_ext) ? h_ext : ye;
		rect_empty = x2s <= x1s || y2s <= y1s;
		rect_last  = (WW'(cx_q + 1'b1) == x2_q) && (HW'(cy_q + 1'b1) == y2_q);
		more_seg   = op_q == OP_BORDER && seg_q != 2'd3;
		seg_nx     = seg_q + 2'd1;
		sg_x = x_q;
		sg_y = y_q;
		sg_w = w_q;
		sg_h = h_q;
		case (seg_nx)
			2'd1: begin
				sg_y = y_q + h_q - 20'sd1;
				sg_h = 20'sd1;
			end
			2'd2: sg_w = 20'sd1;
			2'd3: begin
				sg_x = x_q + w_q - 20'sd1;
				sg_w = 20'sd1;
			end
			default: sg_h = 20'sd1;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (clr_q == clr_n_q) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(cmd.opcode))
						OP_CLEAR: state_d = ST_CLEAR;
						OP_PLOT, OP_FILL:
							state_d = (put_mode == PM_SKIP) ? ST_DONE : ST_SETUP;
						OP_BORDER:
							state_d = (put_mode != PM_SKIP && in_w > 0 && in_h > 0) ?
								ST_SETUP : ST_DONE;
						OP_SPR_ARGB, OP_SPR_GREY:
							state_d = (spr_ok && spr_inb && spr_mode != PM_SKIP) ?
								ST_SETUP : ST_DONE;
						OP_READ: state_d = in_inb ? ST_READ : ST_DONE;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: if (clr_q == clr_n_q) state_d = ST_DONE;
			ST_SETUP: if (rect_empty && !more_seg) state_d = ST_DONE;
				else if (!rect_empty) state_d = ST_RECT;
			ST_RECT: if (rect_last) state_d = more_seg ? ST_SETUP : ST_DONE;
			ST_READ: state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || res.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// sprite raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_ox_q  <= '0;
			spr_oy_q  <= '0;
			spr_w_q   <= '0;
			spr_h_q   <= '0;
			spr_col_q <= '0;
			spr_row_q <= '0;
		end else if (accept) begin
			if (op_t'(cmd.opcode) == OP_SPR_START) begin
				spr_ox_q  <= cmd.pos_x;
				spr_oy_q  <= cmd.pos_y;
				spr_w_q   <= cmd.size_w;
				spr_h_q   <= cmd.size_h;
				spr_col_q <= '0;
				spr_row_q <= '0;
			end else if ((op_t'(cmd.opcode) == OP_SPR_ARGB ||
					op_t'(cmd.opcode) == OP_SPR_GREY) && spr_ok) begin
				if (col_wrap) begin
					spr_col_q <= '0;
					spr_row_q <= spr_row_q + 16'sd1;
				end else begin
					spr_col_q <= spr_col_q + 16'sd1;
				end
			end
		end
	end

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			clr_n_q <= (AW+1)'(DEPTH);
		end else if (state_q == ST_IDLE) begin
			clr_q   <= '0;
			clr_n_q <= (AW+1)'(area);
		end else if ((state_q == ST_INIT || state_q == ST_CLEAR) && clr_q != clr_n_q) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// command datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q       <= op_t'(cmd.opcode);
					x_q        <= in_x;
					y_q        <= in_y;
					w_q        <= in_w;
					h_q        <= in_h;
					seg_q      <= 2'd0;
					res_data_q <= '0;
					cx_q       <= WW'(cmd.pos_x);
					cy_q       <= HW'(cmd.pos_y);
					case (op_t'(cmd.opcode))
						OP_SPR_ARGB, OP_SPR_GREY: begin
							color_q <= spr_color;
							mode_q  <= spr_mode;
							rx_q    <= spr_px;
							ry_q    <= spr_py;
							rw_q    <= 20'sd1;
							rh_q    <= 20'sd1;
						end
						OP_PLOT: begin
							color_q <= cmd.color;
							mode_q  <= put_mode;
							rx_q    <= in_x;
							ry_q    <= in_y;
							rw_q    <= 20'sd1;
							rh_q    <= 20'sd1;
						end
						OP_BORDER: begin
							color_q <= cmd.color;
							mode_q  <= put_mode;
							rx_q    <= in_x;
							ry_q    <= in_y;
							rw_q    <= in_w;
							rh_q    <= 20'sd1;
						end
						default: begin
							color_q <= cmd.color;
							mode_q  <= put_mode;
							rx_q    <= in_x;
							ry_q    <= in_y;
							rw_q    <= in_w;
							rh_q    <= in_h;
						end
					endcase
				end
			end
			ST_SETUP: begin
				x1_q <= WW'(x1s);
				x2_q <= WW'(x2s);
				y2_q <= HW'(y2s);
				cx_q <= WW'(x1s);
				cy_q <= HW'(y1s);
				if (rect_empty && more_seg) begin
					seg_q <= seg_nx;
					rx_q  <= sg_x;
					ry_q  <= sg_y;
					rw_q  <= sg_w;
					rh_q  <= sg_h;
				end
			end
			ST_RECT: begin
				if (WW'(cx_q + 1'b1) == x2_q) begin
					cx_q <= x1_q;
					cy_q <= HW'(cy_q + 1'b1);
				end else begin
					cx_q <= WW'(cx_q + 1'b1);
				end
				if (rect_last && more_seg) begin
					seg_q <= seg_nx;
					rx_q  <= sg_x;
					ry_q  <= sg_y;
					rw_q  <= sg_w;
					rh_q  <= sg_h;
				end
			end
			ST_READ_WAIT: res_data_q <= st_rdata;
			default: ;
		endcase
	end

	// frame store access
	always_comb begin
		pix_prod = PW'(cy_q) * PW'(w_eff) + PW'(cx_q);
		st_color = (state_q == ST_INIT) ? 32'd0 : color_q;
		st_addr  = AW'(pix_prod);
		st_req   = '{valid: 1'b0, mode: PM_WRITE};
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				st_addr = clr_q[AW-1:0];
				st_req  = '{valid: clr_q != clr_n_q, mode: PM_WRITE};
			end
			ST_RECT: st_req = '{valid: 1'b1, mode: mode_q};
			ST_READ: st_req = '{valid: 1'b1, mode: PM_READ};
			default: ;
		endcase
	end

	fbde_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (st_req),
		.addr  (st_addr),
		.wcolor(st_color),
		.rdata (st_rdata)
	);

	// result register
	assign out_load = state_q == ST_DONE && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_data_q;
		end
	end

	assign cmd.ready      = state_q == ST_IDLE;
	assign res.valid      = out_valid_q;
	assign res.read_color = out_data_q;

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !st_req.valid)
		else $error("frame store access while idle");

	a_rect_in_clip: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RECT |-> cx_q < x2_q && cy_q < y2_q && x2_q <= w_eff)
		else $error("pixel walk outside clipped rectangle");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("finished command produced no result");

endmodule

`default_nettype wire
